[rtl/rgbhsv_pkg.sv]
// Shared types for the RGB to HSV converter.
package rgbhsv_pkg;

    typedef struct packed {
        logic valid;
        logic gray;
    } rgbhsv_ctl_t;

endpackage

[rtl/rgbhsv_front.sv]
// Front stage: max, min, hue sector and divider operands, one registered stage.
module rgbhsv_front #(
    parameter int CH_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    output logic                    ready_up,
    input  logic                    ready_in,
    input  logic [CH_BITS-1:0]      red,
    input  logic [CH_BITS-1:0]      green,
    input  logic [CH_BITS-1:0]      blue,
    input  logic [CH_BITS-1:0]      alpha,
    output rgbhsv_pkg::rgbhsv_ctl_t ctl_out,
    output logic [CH_BITS-1:0]      mx_out,
    output logic [CH_BITS-1:0]      alpha_out,
    output logic [CH_BITS+2:0]      hrem_out,
    output logic [CH_BITS+2:0]      hdiv_out,
    output logic [CH_BITS-1:0]      srem_out,
    output logic [CH_BITS-1:0]      sdiv_out,
    output logic [CH_BITS-1:0]      slow_out
);
    import rgbhsv_pkg::*;

    rgbhsv_ctl_t               ctl_reg;
    rgbhsv_ctl_t               ctl_next;
    logic [CH_BITS-1:0]        mx;
    logic [CH_BITS-1:0]        mn;
    logic [CH_BITS-1:0]        delta;
    logic [CH_BITS+2:0]        d6;
    logic signed [CH_BITS+3:0] n_raw;
    logic [CH_BITS+2:0]        n_wrap;
    logic [2*CH_BITS-1:0]      sat_num;
    logic [CH_BITS-1:0]        mx_reg;
    logic [CH_BITS-1:0]        alpha_reg;
    logic [CH_BITS+2:0]        hrem_reg;
    logic [CH_BITS+2:0]        hdiv_reg;
    logic [CH_BITS-1:0]        srem_reg;
    logic [CH_BITS-1:0]        sdiv_reg;
    logic [CH_BITS-1:0]        slow_reg;

    always_comb
    begin
        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        delta = mx - mn;
        d6 = {delta, 2'b00} + {1'b0, delta, 1'b0};

        // later channel wins ties: blue, then green, then red
        if (blue == mx)
        begin
            n_raw = $signed({2'b00, delta, 2'b00}) + $signed({4'b0000, red})
                  - $signed({4'b0000, green});
        end
        else if (green == mx)
        begin
            n_raw = $signed({3'b000, delta, 1'b0}) + $signed({4'b0000, blue})
                  - $signed({4'b0000, red});
        end
        else
        begin
            n_raw = $signed({4'b0000, green}) - $signed({4'b0000, blue});
        end

        if (n_raw < 0)
        begin
            n_wrap = n_raw[CH_BITS+2:0] + d6;
        end
        else
        begin
            n_wrap = n_raw[CH_BITS+2:0];
        end

        // delta * (2^C - 1)
        sat_num = {delta, {CH_BITS{1'b0}}} - {{CH_BITS{1'b0}}, delta};

        ctl_next.valid = valid_in;
        ctl_next.gray  = (delta == '0);
    end

    assign ready_up = !ctl_reg.valid || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (ready_up)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            mx_reg    <= mx;
            alpha_reg <= alpha;
            hrem_reg  <= n_wrap;
            // gray: divisor of one keeps the zero remainder at zero
            hdiv_reg  <= (delta == '0) ? {{(CH_BITS+2){1'b0}}, 1'b1} : d6;
            srem_reg  <= sat_num[2*CH_BITS-1:CH_BITS];
            slow_reg  <= sat_num[CH_BITS-1:0];
            // black: all-ones divisor forces a zero quotient
            sdiv_reg  <= (mx == '0) ? {CH_BITS{1'b1}} : mx;
        end
    end

    assign ctl_out   = ctl_reg;
    assign mx_out    = mx_reg;
    assign alpha_out = alpha_reg;
    assign hrem_out  = hrem_reg;
    assign hdiv_out  = hdiv_reg;
    assign srem_out  = srem_reg;
    assign sdiv_out  = sdiv_reg;
    assign slow_out  = slow_reg;

endmodule

[rtl/rgbhsv_cell.sv]
// Divider cell: one restoring step for hue (when DO_HUE) and one for saturation (when DO_SAT), registered.
module rgbhsv_cell #(
    parameter int CH_BITS  = 8,
    parameter int HUE_BITS = 16,
    parameter bit DO_HUE   = 1'b1,
    parameter bit DO_SAT   = 1'b1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    output logic                    ready_up,
    input  logic                    ready_in,
    input  rgbhsv_pkg::rgbhsv_ctl_t ctl_in,
    input  logic [CH_BITS-1:0]      mx_in,
    input  logic [CH_BITS-1:0]      alpha_in,
    input  logic [CH_BITS+2:0]      hrem_in,
    input  logic [CH_BITS+2:0]      hdiv_in,
    input  logic [HUE_BITS-1:0]     hq_in,
    input  logic [CH_BITS-1:0]      srem_in,
    input  logic [CH_BITS-1:0]      sdiv_in,
    input  logic [CH_BITS-1:0]      slow_in,
    input  logic [CH_BITS-1:0]      sq_in,
    output rgbhsv_pkg::rgbhsv_ctl_t ctl_out,
    output logic [CH_BITS-1:0]      mx_out,
    output logic [CH_BITS-1:0]      alpha_out,
    output logic [CH_BITS+2:0]      hrem_out,
    output logic [CH_BITS+2:0]      hdiv_out,
    output logic [HUE_BITS-1:0]     hq_out,
    output logic [CH_BITS-1:0]      srem_out,
    output logic [CH_BITS-1:0]      sdiv_out,
    output logic [CH_BITS-1:0]      slow_out,
    output logic [CH_BITS-1:0]      sq_out
);
    import rgbhsv_pkg::*;

    rgbhsv_ctl_t          ctl_reg;
    logic [CH_BITS+3:0]   h_trial;
    logic                 h_ge;
    logic [CH_BITS+3:0]   h_diff;
    logic [CH_BITS:0]     s_trial;
    logic                 s_ge;
    logic [CH_BITS:0]     s_diff;
    logic [CH_BITS+2:0]   hrem_next;
    logic [HUE_BITS-1:0]  hq_next;
    logic [CH_BITS-1:0]   srem_next;
    logic [CH_BITS-1:0]   slow_next;
    logic [CH_BITS-1:0]   sq_next;
    logic [CH_BITS-1:0]   mx_reg;
    logic [CH_BITS-1:0]   alpha_reg;
    logic [CH_BITS+2:0]   hrem_reg;
    logic [CH_BITS+2:0]   hdiv_reg;
    logic [HUE_BITS-1:0]  hq_reg;
    logic [CH_BITS-1:0]   srem_reg;
    logic [CH_BITS-1:0]   sdiv_reg;
    logic [CH_BITS-1:0]   slow_reg;
    logic [CH_BITS-1:0]   sq_reg;

    always_comb
    begin
        h_trial = {hrem_in, 1'b0};
        h_ge    = (h_trial >= {1'b0, hdiv_in});
        h_diff  = h_trial - {1'b0, hdiv_in};
        s_trial = {srem_in, slow_in[CH_BITS-1]};
        s_ge    = (s_trial >= {1'b0, sdiv_in});
        s_diff  = s_trial - {1'b0, sdiv_in};

        hrem_next = hrem_in;
        hq_next   = hq_in;
        if (DO_HUE)
        begin
            hrem_next = h_ge ? h_diff[CH_BITS+2:0] : h_trial[CH_BITS+2:0];
            hq_next   = {hq_in[HUE_BITS-2:0], h_ge};
        end

        srem_next = srem_in;
        slow_next = slow_in;
        sq_next   = sq_in;
        if (DO_SAT)
        begin
            srem_next = s_ge ? s_diff[CH_BITS-1:0] : s_trial[CH_BITS-1:0];
            slow_next = {slow_in[CH_BITS-2:0], 1'b0};
            sq_next   = {sq_in[CH_BITS-2:0], s_ge};
        end
    end

    assign ready_up = !ctl_reg.valid || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (ready_up)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && ctl_in.valid)
        begin
            mx_reg    <= mx_in;
            alpha_reg <= alpha_in;
            hrem_reg  <= hrem_next;
            hdiv_reg  <= hdiv_in;
            hq_reg    <= hq_next;
            srem_reg  <= srem_next;
            sdiv_reg  <= sdiv_in;
            slow_reg  <= slow_next;
            sq_reg    <= sq_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign mx_out    = mx_reg;
    assign alpha_out = alpha_reg;
    assign hrem_out  = hrem_reg;
    assign hdiv_out  = hdiv_reg;
    assign hq_out    = hq_reg;
    assign srem_out  = srem_reg;
    assign sdiv_out  = sdiv_reg;
    assign slow_out  = slow_reg;
    assign sq_out    = sq_reg;

endmodule

[rtl/rgb_to_hsv_convert.sv]
// RGB to HSV converter top level: front stage and a chain of divider cells.
//
//   port group   dir   payload                                      handshake
//   input item   in    red, green, blue, alpha                      in_valid / in_stall
//   result item  out   hue, saturation, brightness, alpha_out, gray out_valid / out_stall
//
// One item per clock sustained while out_stall is low. The pipeline is one front
// stage, then one divider cell per quotient bit.
// rst_n clears every stage valid bit; data registers are not reset.
// Stages that hold no item fill while downstream stalls; in_stall rises only when
// every stage is full and out_stall is high.
module rgb_to_hsv_convert #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS     = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    input  logic [CHANNEL_BITS-1:0] alpha,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [HUE_BITS-1:0]     hue,
    output logic [CHANNEL_BITS-1:0] saturation,
    output logic [CHANNEL_BITS-1:0] brightness,
    output logic [CHANNEL_BITS-1:0] alpha_out,
    output logic                    gray
);
    import rgbhsv_pkg::*;

    localparam int Stages = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

    rgbhsv_ctl_t               ctl_c   [Stages+1];
    logic [CHANNEL_BITS-1:0]   mx_c    [Stages+1];
    logic [CHANNEL_BITS-1:0]   alpha_c [Stages+1];
    logic [CHANNEL_BITS+2:0]   hrem_c  [Stages+1];
    logic [CHANNEL_BITS+2:0]   hdiv_c  [Stages+1];
    logic [HUE_BITS-1:0]       hq_c    [Stages+1];
    logic [CHANNEL_BITS-1:0]   srem_c  [Stages+1];
    logic [CHANNEL_BITS-1:0]   sdiv_c  [Stages+1];
    logic [CHANNEL_BITS-1:0]   slow_c  [Stages+1];
    logic [CHANNEL_BITS-1:0]   sq_c    [Stages+1];
    logic                      rdy_c   [Stages+1];
    logic                      front_ready;

    rgbhsv_front #(
        .CH_BITS(CHANNEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .ready_up  (front_ready),
        .ready_in  (rdy_c[0]),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .ctl_out   (ctl_c[0]),
        .mx_out    (mx_c[0]),
        .alpha_out (alpha_c[0]),
        .hrem_out  (hrem_c[0]),
        .hdiv_out  (hdiv_c[0]),
        .srem_out  (srem_c[0]),
        .sdiv_out  (sdiv_c[0]),
        .slow_out  (slow_c[0])
    );

    assign hq_c[0]        = '0;
    assign sq_c[0]        = '0;
    assign rdy_c[Stages]  = !out_stall;
    assign in_stall       = !front_ready;

    for (genvar i = 0; i < Stages; i++)
    begin : g_cell
        rgbhsv_cell #(
            .CH_BITS (CHANNEL_BITS),
            .HUE_BITS(HUE_BITS),
            .DO_HUE  (i < HUE_BITS),
            .DO_SAT  (i < CHANNEL_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ready_up  (rdy_c[i]),
            .ready_in  (rdy_c[i+1]),
            .ctl_in    (ctl_c[i]),
            .mx_in     (mx_c[i]),
            .alpha_in  (alpha_c[i]),
            .hrem_in   (hrem_c[i]),
            .hdiv_in   (hdiv_c[i]),
            .hq_in     (hq_c[i]),
            .srem_in   (srem_c[i]),
            .sdiv_in   (sdiv_c[i]),
            .slow_in   (slow_c[i]),
            .sq_in     (sq_c[i]),
            .ctl_out   (ctl_c[i+1]),
            .mx_out    (mx_c[i+1]),
            .alpha_out (alpha_c[i+1]),
            .hrem_out  (hrem_c[i+1]),
            .hdiv_out  (hdiv_c[i+1]),
            .hq_out    (hq_c[i+1]),
            .srem_out  (srem_c[i+1]),
            .sdiv_out  (sdiv_c[i+1]),
            .slow_out  (slow_c[i+1]),
            .sq_out    (sq_c[i+1])
        );
    end

    assign out_valid  = ctl_c[Stages].valid;
    assign gray       = ctl_c[Stages].gray;
    assign hue        = hq_c[Stages];
    assign saturation = sq_c[Stages];
    assign brightness = mx_c[Stages];
    assign alpha_out  = alpha_c[Stages];

    a_gray_hue_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gray |-> hue == '0)
        else $error("gray item with nonzero hue");

    a_black_sat_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && brightness == '0 |-> saturation == '0 && gray)
        else $error("black item with nonzero saturation or not gray");

    a_color_sat_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !gray |-> saturation != '0 && brightness != '0)
        else $error("colored item with zero saturation");

    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output side can drain");

endmodule
